[rtl/polled_frame_receiver_xor_check_defines.svh]
// Assertion macros shared by the frame receiver RTL.
`ifndef POLLED_FRAME_RECEIVER_XOR_CHECK_DEFINES_SVH
`define POLLED_FRAME_RECEIVER_XOR_CHECK_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PFRX_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pfrx: implication check failed");

// Condition must never hold.
`define PFRX_ASSERT_NEVER(name, clk, rst_n, cond) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("pfrx: forbidden condition seen");

`endif

[rtl/pfrx_pkg.sv]
// Types, codes and constants of the polled frame receiver.
`default_nettype none

package pfrx_pkg;

	localparam int LONG_FRAME_BYTES_DEF  = 76;
	localparam int SHORT_FRAME_BYTES_DEF = 22;

	// Four stores plus one receive buffer, rotated by a bank map.
	localparam int NUM_STORES = 4;
	localparam int NUM_BANKS  = 5;
	localparam int BANK_W     = 3;

	localparam logic [7:0] REQ_C0       = 8'hc0;
	localparam logic [7:0] REQ_48       = 8'h48;
	localparam logic [7:0] REQ_50       = 8'h50;
	localparam logic [7:0] E8_REQ_RESET = 8'd232;
	localparam logic [7:0] LEAD_E8      = 8'd5;
	localparam logic [7:0] LEAD_C0      = 8'd0;

	typedef enum logic [1:0] {
		STEP_C0 = 2'd0,
		STEP_E8 = 2'd1,
		STEP_48 = 2'd2,
		STEP_50 = 2'd3
	} step_t;

	typedef enum logic [1:0] {
		KIND_POLL = 2'd0,
		KIND_RX   = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		EV_NONE     = 2'd0,
		EV_STORED   = 2'd1,
		EV_REJECTED = 2'd2
	} ev_t;

	typedef enum logic [1:0] {
		RD_ZERO  = 2'd0,
		RD_BYTE0 = 2'd1,
		RD_MEM   = 2'd2
	} rd_src_t;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] rx_byte;
		logic       line_error;
		logic [1:0] frame_select;
		logic [6:0] byte_index;
	} req_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [1:0] frame_event;
		logic [1:0] frame_which;
		logic [7:0] read_data;
	} rsp_t;

	// Result fields known at acceptance, plus how to finish the read.
	typedef struct packed {
		logic              tx_valid;
		logic [7:0]        tx_byte;
		logic [1:0]        frame_event;
		logic [1:0]        frame_which;
		rd_src_t           rd_src;
		logic [7:0]        rd_byte0;
		logic [BANK_W-1:0] rd_bank;
	} pre_t;

	typedef struct packed {
		logic              en;
		logic [BANK_W-1:0] bank;
		logic [7:0]        data;
	} wr_t;

endpackage

`default_nettype wire

[rtl/pfrx_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module pfrx_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 76
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/pfrx_ctrl.sv]
// Poll sequencer, frame judging and bank map of the frame receiver.
`default_nettype none

module pfrx_ctrl
	import pfrx_pkg::*;
#(
	parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
	parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [7:0]                          cfg_wr_data,
	input  wire logic                                accept,
	input  wire req_t                                req,
	output pre_t                                     pre,
	output wr_t                                      wr,
	output logic      [$clog2(LONG_FRAME_BYTES)-1:0] wr_addr,
	output logic                                     rd_en,
	output logic      [$clog2(LONG_FRAME_BYTES)-1:0] rd_addr
);

	localparam int CNT_W  = $clog2(LONG_FRAME_BYTES + 1);
	localparam int ADDR_W = $clog2(LONG_FRAME_BYTES);

	step_t             step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [7:0]        chk_q;
	logic [7:0]        lead_q;
	logic [7:0]        e8_req_q;
	logic [BANK_W-1:0] map_q [NUM_STORES];
	logic [BANK_W-1:0] rx_bank_q;
	logic [7:0]        byte0_q [NUM_STORES];
	logic [NUM_STORES-1:0] stored_q;

	kind_t            kind;
	step_t            step_nx;
	step_t            sel;
	logic             rx_take;
	logic [CNT_W-1:0] cnt_inc;
	logic [7:0]       chk_nx;
	logic [7:0]       lead_cur;
	logic             judge;
	logic             ok;
	int               rd_limit;

	assign kind     = kind_t'(req.kind);
	assign sel      = step_t'(req.frame_select);
	assign step_nx  = step_t'(step_q + 2'd1);
	assign cnt_inc  = cnt_q + CNT_W'(1);
	assign chk_nx   = chk_q ^ req.rx_byte;
	assign lead_cur = (cnt_q == '0) ? req.rx_byte : lead_q;
	assign rx_take  = accept && (kind == KIND_RX) && !req.line_error
		&& (cnt_q < CNT_W'(LONG_FRAME_BYTES));
	assign rd_limit = (sel == STEP_E8) ? SHORT_FRAME_BYTES : LONG_FRAME_BYTES;

	always_comb begin
		// An e8 frame is judged at the short length only; others at the full length.
		if (step_q == STEP_E8) begin
			judge = (int'(cnt_inc) == SHORT_FRAME_BYTES);
			ok    = (lead_cur == LEAD_E8) && (chk_nx == 8'd0);
		end else begin
			judge = (int'(cnt_inc) == LONG_FRAME_BYTES);
			ok    = (step_q != STEP_C0) || ((lead_cur == LEAD_C0) && (chk_nx == 8'd0));
		end
	end

	always_comb begin
		pre        = '0;
		pre.rd_src = RD_ZERO;
		unique case (kind)
			KIND_POLL: begin
				pre.tx_valid = 1'b1;
				unique case (step_nx)
					STEP_C0: pre.tx_byte = REQ_C0;
					STEP_E8: pre.tx_byte = e8_req_q;
					STEP_48: pre.tx_byte = REQ_48;
					STEP_50: pre.tx_byte = REQ_50;
				endcase
			end
			KIND_RX: begin
				if (rx_take && judge) begin
					pre.frame_event = ok ? EV_STORED : EV_REJECTED;
					pre.frame_which = step_q;
				end
			end
			KIND_READ: begin
				// Byte 0 lives in a register; the rest comes from the store bank.
				if (int'(req.byte_index) < rd_limit) begin
					if (req.byte_index == 7'd0) begin
						pre.rd_src   = RD_BYTE0;
						pre.rd_byte0 = byte0_q[sel];
					end else if (stored_q[sel]
						&& (int'(req.byte_index) < LONG_FRAME_BYTES)) begin
						pre.rd_src  = RD_MEM;
						pre.rd_bank = map_q[sel];
					end
				end
			end
			KIND_NONE: begin
			end
		endcase
	end

	assign wr.en   = rx_take;
	assign wr.bank = rx_bank_q;
	assign wr.data = req.rx_byte;
	assign wr_addr = cnt_q[ADDR_W-1:0];
	assign rd_en   = accept && (kind == KIND_READ);
	assign rd_addr = (int'(req.byte_index) < LONG_FRAME_BYTES)
		? req.byte_index[ADDR_W-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= STEP_50;
			cnt_q     <= '0;
			chk_q     <= '0;
			lead_q    <= '0;
			e8_req_q  <= E8_REQ_RESET;
			rx_bank_q <= BANK_W'(NUM_STORES);
			stored_q  <= '0;
			for (int i = 0; i < NUM_STORES; i++) begin
				map_q[i]   <= BANK_W'(i);
				byte0_q[i] <= '0;
			end
		end else begin
			if (cfg_wr_en) begin
				e8_req_q <= cfg_wr_data;
			end
			if (accept && (kind == KIND_POLL)) begin
				cnt_q  <= '0;
				chk_q  <= '0;
				step_q <= step_nx;
			end
			if (rx_take) begin
				cnt_q <= cnt_inc;
				chk_q <= chk_nx;
				if (cnt_q == '0) begin
					lead_q <= req.rx_byte;
				end
				if (judge) begin
					if (ok) begin
						// Swap: the filled buffer becomes the store, the old store the buffer.
						map_q[step_q]    <= rx_bank_q;
						rx_bank_q        <= map_q[step_q];
						byte0_q[step_q]  <= '0;
						stored_q[step_q] <= 1'b1;
					end else begin
						byte0_q[step_q] <= byte0_q[step_q] + 8'd1;
					end
				end
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pfrx_rsp.sv]
// Result stage and output register of the frame receiver.
`default_nettype none

module pfrx_rsp
	import pfrx_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       accept,
	output logic            take_ready,
	input  wire pre_t       pre,
	input  wire logic [7:0] bank_rdata [NUM_BANKS],
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp
);

	logic valid_s1;
	pre_t pre_s1;
	rsp_t rsp_q;
	rsp_t res;
	logic advance;

	assign advance    = valid_s1 && (!rsp_valid || rsp_ready);
	assign take_ready = !valid_s1 || advance;

	always_comb begin
		res.tx_valid    = pre_s1.tx_valid;
		res.tx_byte     = pre_s1.tx_byte;
		res.frame_event = pre_s1.frame_event;
		res.frame_which = pre_s1.frame_which;
		unique case (pre_s1.rd_src)
			RD_BYTE0: res.read_data = pre_s1.rd_byte0;
			RD_MEM:   res.read_data = bank_rdata[pre_s1.rd_bank];
			default:  res.read_data = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pre_s1 <= pre;
		end
		if (advance) begin
			rsp_q <= res;
		end
	end

	assign rsp = rsp_q;

endmodule

`default_nettype wire

[rtl/polled_frame_receiver_xor_check.sv]
// Top level of the polled frame receiver with XOR frame check.
// Items enter on req (req_valid/req_ready): poll ticks, received bytes and
// reads of stored frame bytes. Every item yields exactly one result item on
// rsp (rsp_valid/rsp_ready) carrying the request byte, frame event or read data.
// The e8 request byte is written through cfg_wr_en/cfg_wr_data; the user must
// write it only while idle, since the block itself does not enforce this. The state
// update and the store read happen at acceptance, the store read data is
// registered with the item in the middle stage, and the result register loads when
// it is free. One item is accepted every cycle while the result register drains.
// Frames rotate through five 76-byte banks by a bank map, so a kept frame
// is published by swapping banks instead of copying bytes.
// Reset clears the poll sequence, count, check, failure counters and store
// flags at once; no clearing pass is needed. When rsp_ready is low, the result
// register holds, one more item is taken into the middle stage, then req_ready drops.
`default_nettype none
`include "polled_frame_receiver_xor_check_defines.svh"

module polled_frame_receiver_xor_check
	import pfrx_pkg::*;
#(
	parameter int LONG_FRAME_BYTES  = LONG_FRAME_BYTES_DEF,
	parameter int SHORT_FRAME_BYTES = SHORT_FRAME_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_wr_en,
	input  wire logic [7:0] cfg_wr_data,
	input  wire logic       req_valid,
	output logic            req_ready,
	input  wire req_t       req,
	output logic            rsp_valid,
	input  wire logic       rsp_ready,
	output rsp_t            rsp
);

	localparam int ADDR_W = $clog2(LONG_FRAME_BYTES);

	logic              accept;
	pre_t              pre;
	wr_t               wr;
	logic [ADDR_W-1:0] wr_addr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        bank_rdata [NUM_BANKS];

	assign accept = req_valid && req_ready;

	pfrx_ctrl #(
		.LONG_FRAME_BYTES (LONG_FRAME_BYTES),
		.SHORT_FRAME_BYTES(SHORT_FRAME_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.accept     (accept),
		.req        (req),
		.pre        (pre),
		.wr         (wr),
		.wr_addr    (wr_addr),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr)
	);

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		pfrx_ram #(
			.WIDTH(8),
			.DEPTH(LONG_FRAME_BYTES)
		) u_ram (
			.clk  (clk),
			.we   (wr.en && (wr.bank == BANK_W'(b))),
			.waddr(wr_addr),
			.wdata(wr.data),
			.re   (rd_en),
			.raddr(rd_addr),
			.rdata(bank_rdata[b])
		);
	end

	pfrx_rsp u_rsp (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.take_ready(req_ready),
		.pre       (pre),
		.bank_rdata(bank_rdata),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`PFRX_ASSERT_IMPLY(a_ready_when_out_empty, clk, arst_n, !rsp_valid, req_ready)
	`PFRX_ASSERT_IMPLY(a_which_only_with_event, clk, arst_n, rsp_valid && rsp.frame_event == EV_NONE, rsp.frame_which == STEP_C0)
	`PFRX_ASSERT_NEVER(a_poll_has_no_side_data, clk, arst_n, rsp_valid && rsp.tx_valid && (rsp.frame_event != EV_NONE || rsp.read_data != 8'd0))

endmodule

`default_nettype wire

[bench/pfrx_score_pkg.sv]
// Scoreboard for the polled frame receiver: predicted state and result checks.
package pfrx_score_pkg;
	import pfrx_pkg::*;

	localparam int LONG_N  = LONG_FRAME_BYTES_DEF;
	localparam int SHORT_N = SHORT_FRAME_BYTES_DEF;

	class frame_rx_scoreboard;
		logic [7:0]  e8_req;
		step_t       last_step;
		int          byte_count;
		logic [7:0]  run_check;
		logic [7:0]  rx_buf [LONG_N];
		logic [7:0]  short_store [SHORT_N];
		logic [7:0]  long_store [3][LONG_N];
		rsp_t        resp_due [$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned kept;
		int unsigned rejected;

		function new();
			e8_req = E8_REQ_RESET;
			last_step = STEP_50;
			byte_count = 0;
			run_check = 8'h00;
			mismatches = 0;
			checked = 0;
			kept = 0;
			rejected = 0;
			foreach (rx_buf[i]) rx_buf[i] = 8'h00;
			foreach (short_store[i]) short_store[i] = 8'h00;
			foreach (long_store[s, i]) long_store[s][i] = 8'h00;
		endfunction

		// c0, 48 and 50 frames each have their own slot in the long store array
		function int slot_of(logic [1:0] s);
			return (s == STEP_C0) ? 0 : (s == STEP_48) ? 1 : 2;
		endfunction

		// Update the state for an accepted item and queue the result it causes.
		function void log_request(req_t r);
			rsp_t       want;
			logic [1:0] nxt;
			int         slot;
			int         i;
			want = '0;
			case (r.kind)
				KIND_POLL: begin
					byte_count = 0;
					run_check = 8'h00;
					nxt = last_step + 2'd1;
					last_step = step_t'(nxt);
					want.tx_valid = 1'b1;
					case (last_step)
						STEP_C0: want.tx_byte = REQ_C0;
						STEP_E8: want.tx_byte = e8_req;
						STEP_48: want.tx_byte = REQ_48;
						default: want.tx_byte = REQ_50;
					endcase
				end
				KIND_RX: begin
					// drop bad bytes and anything past a full buffer
					if (!r.line_error && byte_count < LONG_N) begin
						rx_buf[byte_count] = r.rx_byte;
						byte_count++;
						run_check ^= r.rx_byte;
						if (last_step == STEP_E8) begin
							if (byte_count == SHORT_N) begin
								want.frame_which = STEP_E8;
								if (rx_buf[0] == LEAD_E8 && run_check == 8'h00) begin
									for (i = 0; i < SHORT_N; i++) short_store[i] = rx_buf[i];
									short_store[0] = 8'h00;
									want.frame_event = EV_STORED;
									kept++;
								end else begin
									short_store[0] = short_store[0] + 8'd1;
									want.frame_event = EV_REJECTED;
									rejected++;
								end
							end
						end else if (byte_count == LONG_N) begin
							slot = slot_of(last_step);
							want.frame_which = last_step;
							if (last_step != STEP_C0 ||
									(rx_buf[0] == LEAD_C0 && run_check == 8'h00)) begin
								for (i = 0; i < LONG_N; i++) long_store[slot][i] = rx_buf[i];
								long_store[slot][0] = 8'h00;
								want.frame_event = EV_STORED;
								kept++;
							end else begin
								long_store[slot][0] = long_store[slot][0] + 8'd1;
								want.frame_event = EV_REJECTED;
								rejected++;
							end
						end
					end
				end
				KIND_READ: begin
					if (r.frame_select == STEP_E8) begin
						if (r.byte_index < SHORT_N) want.read_data = short_store[r.byte_index];
					end else if (r.byte_index < LONG_N) begin
						want.read_data = long_store[slot_of(r.frame_select)][r.byte_index];
					end
				end
				default: ;
			endcase
			resp_due.push_back(want);
		endfunction

		function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// Compare one accepted result with the oldest expectation.
		function void match_response(rsp_t got);
			rsp_t want;
			if (resp_due.size() == 0) begin
				mismatches++;
				$display("%0t: result with nothing pending, expected none, actual %h",
					$time, got);
				return;
			end
			want = resp_due.pop_front();
			checked++;
			cmp_field("tx_valid", want.tx_valid, got.tx_valid);
			cmp_field("tx_byte", want.tx_byte, got.tx_byte);
			cmp_field("frame_event", want.frame_event, got.frame_event);
			cmp_field("frame_which", want.frame_which, got.frame_which);
			cmp_field("read_data", want.read_data, got.read_data);
		endfunction
	endclass

endpackage

[bench/tb_polled_frame_receiver_xor_check.sv]
// Testbench top: drives random and well-formed frame traffic into the receiver.
module tb_polled_frame_receiver_xor_check;
	import pfrx_pkg::*;
	import pfrx_score_pkg::*;

	localparam int REQ_W = $bits(req_t);

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [7:0] cfg_wr_data = 8'h00;
	logic       req_valid = 1'b0;
	req_t       req = '0;
	logic       rsp_ready = 1'b0;
	logic       req_ready;
	logic       rsp_valid;
	rsp_t       rsp;

	frame_rx_scoreboard board;
	int unsigned n_sent = 0;
	bit          sender_quiet = 1'b0;

	polled_frame_receiver_xor_check DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int unsigned idle_len();
		int unsigned p;
		p = $urandom_range(0, 99);
		if (p < 60) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic req_t make_req(kind_t k, logic [7:0] b, logic err, logic [1:0] sel,
			logic [6:0] idx);
		req_t r;
		r.kind = k;
		r.rx_byte = b;
		r.line_error = err;
		r.frame_select = sel;
		r.byte_index = idx;
		return r;
	endfunction

	function automatic req_t random_read();
		logic [6:0] idx;
		if ($urandom_range(0, 9) == 0) idx = 7'($urandom_range(0, 127));
		else idx = 7'($urandom_range(0, LONG_N - 1));
		return make_req(KIND_READ, 8'($urandom), 1'($urandom), 2'($urandom), idx);
	endfunction

	// Hold the item until accepted, then idle for a random gap.
	task automatic issue(input req_t it);
		int unsigned gap;
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		board.log_request(it);
		n_sent++;
		gap = sender_quiet ? 0 : idle_len();
		if (gap != 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and wait until every pending result is back.
	task automatic settle();
		req_valid <= 1'b0;
		while (board.resp_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_e8_byte(input logic [7:0] v);
		cfg_wr_data <= v;
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		board.e8_req = v;
	endtask

	// One frame for step s: mostly good, some with a bad lead byte, a bad check
	// or cut short; line errors and reads are mixed in, extra bytes may follow.
	task automatic send_frame(input step_t s);
		int unsigned len, quality, stop_at, i;
		logic [7:0]  lead, b, acc, flip;
		len = (s == STEP_E8) ? SHORT_N : LONG_N;
		quality = $urandom_range(0, 99);
		stop_at = (quality >= 90) ? $urandom_range(1, len - 1) : len;
		if (s == STEP_E8) lead = LEAD_E8;
		else if (s == STEP_C0) lead = LEAD_C0;
		else lead = 8'($urandom);
		if (quality >= 65 && quality < 80) begin
			flip = 8'($urandom_range(1, 255));
			lead ^= flip;
		end
		acc = 8'h00;
		for (i = 0; i < stop_at; i++) begin
			if ($urandom_range(0, 99) < 5)
				issue(make_req(KIND_RX, 8'($urandom), 1'b1, 2'($urandom), 7'($urandom)));
			if ($urandom_range(0, 99) < 3) issue(random_read());
			if (i == 0) begin
				b = lead;
			end else if (i == len - 1) begin
				b = acc;
				if (quality >= 80 && quality < 90) begin
					flip = 8'($urandom_range(1, 255));
					b ^= flip;
				end
			end else begin
				b = 8'($urandom);
			end
			acc ^= b;
			issue(make_req(KIND_RX, b, 1'b0, 2'($urandom), 7'($urandom)));
		end
		// trailing bytes run into the full buffer or follow a short frame
		if ($urandom_range(0, 99) < 30)
			repeat ($urandom_range(1, 70)) issue(make_req(KIND_RX, 8'($urandom), 1'b0,
				2'($urandom), 7'($urandom)));
	endtask

	// Result side: check accepted results and stall at random.
	initial begin : rsp_side
		int unsigned hold;
		bit          quiet;
		hold = 0;
		quiet = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready) board.match_response(rsp);
			if ($urandom_range(0, 299) == 0) quiet = !quiet;
			if (hold != 0) begin
				hold--;
				rsp_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < 25) begin
				hold = idle_len();
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin : watchdog
		#20_000_000;
		$display("%0t: run timed out", $time);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : stimulus
		int unsigned phase, goal, p;
		logic [7:0]  setting;
		board = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reads of the cleared stores at the edges, unused kind,
		// a dropped byte, byte extremes and a full request cycle.
		issue(make_req(KIND_READ, 8'h00, 1'b0, STEP_C0, 7'd0));
		issue(make_req(KIND_READ, 8'h00, 1'b0, STEP_E8, 7'd21));
		issue(make_req(KIND_READ, 8'h00, 1'b0, STEP_E8, 7'd22));
		issue(make_req(KIND_READ, 8'h00, 1'b0, STEP_C0, 7'd75));
		issue(make_req(KIND_READ, 8'h00, 1'b0, STEP_48, 7'd76));
		issue(make_req(KIND_READ, 8'hff, 1'b1, STEP_50, 7'd127));
		issue('1);
		issue(make_req(KIND_RX, 8'hff, 1'b1, STEP_50, 7'd127));
		issue(make_req(KIND_POLL, 8'h00, 1'b0, STEP_C0, 7'd0));
		issue(make_req(KIND_RX, 8'h00, 1'b0, STEP_C0, 7'd0));
		issue(make_req(KIND_RX, 8'hff, 1'b0, STEP_50, 7'd127));
		issue(make_req(KIND_RX, 8'h5a, 1'b1, STEP_E8, 7'd3));
		issue(make_req(KIND_POLL, 8'hff, 1'b1, STEP_50, 7'd127));
		issue(make_req(KIND_POLL, 8'h00, 1'b0, STEP_C0, 7'd0));
		issue(make_req(KIND_POLL, 8'h00, 1'b0, STEP_C0, 7'd0));
		issue(make_req(KIND_POLL, 8'h00, 1'b0, STEP_C0, 7'd0));
		issue(make_req(KIND_READ, 8'h00, 1'b0, STEP_50, 7'd0));

		for (phase = 0; phase < 4; phase++) begin
			if (phase != 0) begin
				settle();
				case (phase)
					1: setting = 8'h00;
					2: setting = 8'hff;
					default: setting = 8'($urandom);
				endcase
				write_e8_byte(setting);
			end
			goal = n_sent + 300;
			while (n_sent < goal) begin
				sender_quiet = ($urandom_range(0, 3) == 0);
				p = $urandom_range(0, 99);
				if (p < 60) begin
					issue(make_req(KIND_POLL, 8'($urandom), 1'($urandom), 2'($urandom),
						7'($urandom)));
					send_frame(board.last_step);
				end else if (p < 80) begin
					repeat ($urandom_range(4, 12)) issue(random_read());
				end else begin
					repeat ($urandom_range(1, 8)) begin
						logic [REQ_W-1:0] raw;
						raw = REQ_W'($urandom);
						issue(raw);
					end
				end
			end
		end

		settle();
		if (board.resp_due.size() != 0) begin
			board.mismatches++;
			$display("%0t: %0d results never arrived", $time, board.resp_due.size());
		end
		$display("Sent %0d items over four e8 request settings, %0d results checked.",
			n_sent, board.checked);
		$display("Frames kept: %0d, frames rejected: %0d, mismatches: %0d.",
			board.kept, board.rejected, board.mismatches);
		if (board.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
